/* hdl/ssp_pkg.sv */
// shared types, constants and helper functions for the sunrise/sunset cell pipeline
package ssp_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANG_BITS     = 24;
    localparam int DIV_SHIFT    = ANG_BITS - FRAC_BITS;
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;

    localparam int LAT_W      = 24;
    localparam int LON_W      = 25;
    localparam int HOUR_W     = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    // 24 hours is 3 * 2^(F+3)
    localparam int WRAP_SHIFT = FRAC_BITS + 3;
    localparam int HOUR_FULL  = 24 << FRAC_BITS;
    localparam int HALF_DAY   = 12 << FRAC_BITS;
    localparam int WRAP_BIAS  = 6 * HOUR_FULL;
    localparam int LAT_FULL   = 90 << FRAC_BITS;
    localparam int LON_BIAS   = 30 << 22;
    localparam int LON_OFFS   = 1 << 22;
    localparam int HALF_ROUND = 15 << (DIV_SHIFT - 1);

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [31:0] ANG_90  = 32'd1509949440;
    localparam logic [31:0] ANG_180 = 32'd3019898880;

    typedef enum logic [1:0] {
        ST_NORMAL       = 2'd0,
        ST_NO_DATA      = 2'd1,
        ST_POLAR_NIGHT  = 2'd2,
        ST_MIDNIGHT_SUN = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECL_SINE    = 3'd0,
        CFG_DECL_COSINE  = 3'd1,
        CFG_HOUR_OFFSET  = 3'd2,
        CFG_HORIZON_SINE = 3'd3,
        CFG_WORLD_TIME   = 3'd4
    } t_cfg_index;

    // control that travels beside the data through every stage
    typedef struct packed {
        logic               valid;
        t_status            status;
        logic               lat_neg;
        logic               zero_den;
        logic signed [24:0] base;
    } t_side;

    // atan(2^-i) in degrees Q.24
    function automatic logic [31:0] atan_q24(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd754974720;
            1:  v = 32'd445687602;
            2:  v = 32'd235489088;
            3:  v = 32'd119537938;
            4:  v = 32'd60000934;
            5:  v = 32'd30029717;
            6:  v = 32'd15018523;
            7:  v = 32'd7509720;
            8:  v = 32'd3754917;
            9:  v = 32'd1877466;
            10: v = 32'd938734;
            11: v = 32'd469367;
            12: v = 32'd234684;
            13: v = 32'd117342;
            14: v = 32'd58671;
            15: v = 32'd29335;
            16: v = 32'd14668;
            17: v = 32'd7334;
            18: v = 32'd3667;
            19: v = 32'd1833;
            20: v = 32'd917;
            21: v = 32'd458;
            22: v = 32'd229;
            23: v = 32'd115;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // floor(v / 15) by reciprocal, exact below 15 * 2^23
    function automatic logic [22:0] div15(input logic [26:0] v);
        logic [55:0] p;
        p = {29'd0, v} * 56'd286331154;
        return p[54:32];
    endfunction

    // u mod 3 for u below 64
    function automatic logic [1:0] mod3(input logic [5:0] u);
        logic [11:0] p;
        logic [4:0]  q;
        logic [6:0]  m;
        p = {6'd0, u} * 12'd43;
        q = p[11:7];
        m = {1'b0, u} - {q, 1'b0} - {2'd0, q};
        return m[1:0];
    endfunction

    // non-negative value below 2^25 taken modulo 24 hours
    function automatic logic [HOUR_W-1:0] wrap24(input logic [24:0] v);
        return {mod3(v[24:WRAP_SHIFT]), v[WRAP_SHIFT-1:0]};
    endfunction

endpackage

/* hdl/ssp_rot_cordic.sv */
// pipelined rotation cordic giving cos and sin of the latitude
module ssp_rot_cordic import ssp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic signed [32:0] i_angle,
    input  t_side              i_side,
    output logic signed [32:0] o_cos,
    output logic signed [32:0] o_sin,
    output t_side              o_side
);

    logic signed [32:0] w_x [0:CORDIC_STEPS];
    logic signed [32:0] w_y [0:CORDIC_STEPS];
    logic signed [32:0] w_z [0:CORDIC_STEPS];
    t_side              w_side [0:CORDIC_STEPS];

    assign w_x[0]    = CORDIC_GAIN;
    assign w_y[0]    = '0;
    assign w_z[0]    = i_angle;
    assign w_side[0] = i_side;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [32:0] r_x, r_y, r_z;
        logic signed [32:0] n_x, n_y, n_z;
        t_side              r_side;

        always_comb begin
            if (!w_z[i][32]) begin
                n_x = w_x[i] - (w_y[i] >>> i);
                n_y = w_y[i] + (w_x[i] >>> i);
                n_z = w_z[i] - signed'({1'b0, atan_q24(i)});
            end else begin
                n_x = w_x[i] + (w_y[i] >>> i);
                n_y = w_y[i] - (w_x[i] >>> i);
                n_z = w_z[i] + signed'({1'b0, atan_q24(i)});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else if (i_en) begin
                r_side <= w_side[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
        end

        assign w_x[i+1]    = r_x;
        assign w_y[i+1]    = r_y;
        assign w_z[i+1]    = r_z;
        assign w_side[i+1] = r_side;
    end

    assign o_cos  = w_x[CORDIC_STEPS];
    assign o_sin  = w_y[CORDIC_STEPS];
    assign o_side = w_side[CORDIC_STEPS];

endmodule

/* hdl/ssp_isqrt.sv */
// pipelined integer square root, one result bit per stage
module ssp_isqrt import ssp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [61:0]        i_value,
    input  logic signed [31:0] i_x,
    input  t_side              i_side,
    output logic [30:0]        o_root,
    output logic signed [31:0] o_x,
    output t_side              o_side
);

    logic [63:0]        w_v [0:SQRT_STEPS];
    logic [63:0]        w_r [0:SQRT_STEPS];
    logic signed [31:0] w_x [0:SQRT_STEPS];
    t_side              w_side [0:SQRT_STEPS];

    assign w_v[0]    = {2'd0, i_value};
    assign w_r[0]    = '0;
    assign w_x[0]    = i_x;
    assign w_side[0] = i_side;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - j));
        logic [63:0]        r_v, r_r, n_v, n_r;
        logic signed [31:0] r_x;
        t_side              r_side;

        always_comb begin
            if (w_v[j] >= w_r[j] + BIT) begin
                n_v = w_v[j] - (w_r[j] + BIT);
                n_r = (w_r[j] >> 1) + BIT;
            end else begin
                n_v = w_v[j];
                n_r = w_r[j] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else if (i_en) begin
                r_side <= w_side[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v <= n_v;
                r_r <= n_r;
                r_x <= w_x[j];
            end
        end

        assign w_v[j+1]    = r_v;
        assign w_r[j+1]    = r_r;
        assign w_x[j+1]    = r_x;
        assign w_side[j+1] = r_side;
    end

    assign o_root = w_r[SQRT_STEPS][30:0];
    assign o_x    = w_x[SQRT_STEPS];
    assign o_side = w_side[SQRT_STEPS];

endmodule

/* hdl/ssp_vec_cordic.sv */
// pipelined vectoring cordic giving atan2(y, x) in degrees
module ssp_vec_cordic import ssp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic signed [31:0] i_x,
    input  logic [30:0]        i_y,
    input  t_side              i_side,
    output logic signed [33:0] o_angle,
    output t_side              o_side
);

    logic signed [33:0] w_x [0:CORDIC_STEPS];
    logic signed [33:0] w_y [0:CORDIC_STEPS];
    logic signed [33:0] w_z [0:CORDIC_STEPS];
    t_side              w_side [0:CORDIC_STEPS];
    logic signed [33:0] w_x0, w_y0, w_z0;

    // left half plane: rotate by 90 degrees first
    always_comb begin
        if (i_x[31]) begin
            w_x0 = signed'({3'd0, i_y});
            w_y0 = -{{2{i_x[31]}}, i_x};
            w_z0 = signed'({2'd0, ANG_90});
        end else begin
            w_x0 = {{2{i_x[31]}}, i_x};
            w_y0 = signed'({3'd0, i_y});
            w_z0 = '0;
        end
    end
    assign w_x[0]    = w_x0;
    assign w_y[0]    = w_y0;
    assign w_z[0]    = w_z0;
    assign w_side[0] = i_side;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [33:0] r_x, r_y, r_z;
        logic signed [33:0] n_x, n_y, n_z;
        t_side              r_side;

        always_comb begin
            if (w_y[i] > 34'sd0) begin
                n_x = w_x[i] + (w_y[i] >>> i);
                n_y = w_y[i] - (w_x[i] >>> i);
                n_z = w_z[i] + signed'({2'd0, atan_q24(i)});
            end else begin
                n_x = w_x[i] - (w_y[i] >>> i);
                n_y = w_y[i] + (w_x[i] >>> i);
                n_z = w_z[i] - signed'({2'd0, atan_q24(i)});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else if (i_en) begin
                r_side <= w_side[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
        end

        assign w_x[i+1]    = r_x;
        assign w_y[i+1]    = r_y;
        assign w_z[i+1]    = r_z;
        assign w_side[i+1] = r_side;
    end

    assign o_angle = w_z[CORDIC_STEPS];
    assign o_side  = w_side[CORDIC_STEPS];

endmodule

/* hdl/sunrise_sunset_per_cell_core.sv */
// top level of the per-cell sunrise, sunset and day length pipeline
//
// usage
//   input channel: i_in_valid / o_in_stall with latitude, longitude and the
//   no-data flag; a request is taken at a clock edge with valid high and
//   stall low. output channel: o_out_valid / i_out_stall with sunrise,
//   sunset, day length and cell status, one result per request, in order.
//   configuration: i_cfg_valid / o_cfg_ready, index and data; ready is
//   always high, so each mapped write lands. write only while the pipe is empty.
// throughput and pipeline
//   one request per cycle while the output is not held. a taken request
//   runs through input and setup stages, 24 rotation cordic stages,
//   multiply and normalize stages, 32 square root stages, 24 vectoring
//   cordic stages, hour conversion and wrap stages to the output register.
// stall and reset
//   the whole pipe holds while the output register is full and stalled;
//   o_in_stall then rises and nothing in flight is lost or repeated.
//   synchronous reset clears all valid bits and loads the register defaults.
module sunrise_sunset_per_cell_core import ssp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [LAT_W-1:0]      i_latitude,
    input  logic [LON_W-1:0]      i_longitude,
    input  logic                  i_cell_missing,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [HOUR_W-1:0]     o_sunrise_hour,
    output logic [HOUR_W-1:0]     o_sunset_hour,
    output logic [HOUR_W-1:0]     o_day_length,
    output logic [1:0]            o_cell_status,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // global advance: every stage moves unless the output is held
    logic w_en;
    assign w_en        = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic signed [15:0] r_decl_sine;
    logic [14:0]        r_decl_cos;
    logic signed [21:0] r_hour_offset;
    logic signed [15:0] r_horizon_sine;
    logic               r_world_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl_sine    <= '0;
            r_decl_cos     <= 15'd32767;
            r_hour_offset  <= '0;
            r_horizon_sine <= -16'sd476;
            r_world_time   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DECL_SINE:    r_decl_sine    <= i_cfg_data[15:0];
                CFG_DECL_COSINE:  r_decl_cos     <= i_cfg_data[14:0];
                CFG_HOUR_OFFSET:  r_hour_offset  <= i_cfg_data;
                CFG_HORIZON_SINE: r_horizon_sine <= i_cfg_data[15:0];
                CFG_WORLD_TIME:   r_world_time   <= i_cfg_data[0];
                default: ;  // unmapped indexes are dropped
            endcase
        end
    end

    // stage a: saturate latitude, take magnitude, bias longitude for floor divide
    logic signed [LAT_W-1:0] w_lat_sat;
    logic [22:0]             w_lat_abs;
    logic [28:0]             w_lon_biased;
    logic signed [32:0]      r_a_z;
    logic [26:0]             r_a_lonv;
    t_side                   r_a_side;
    t_side                   w_a_side;

    always_comb begin
        if ($signed(i_latitude) > LAT_W'(LAT_FULL)) begin
            w_lat_sat = LAT_W'(LAT_FULL);
        end else if ($signed(i_latitude) < -LAT_W'(LAT_FULL)) begin
            w_lat_sat = -LAT_W'(LAT_FULL);
        end else begin
            w_lat_sat = i_latitude;
        end
        w_lat_abs = w_lat_sat[LAT_W-1] ? 23'(-w_lat_sat) : w_lat_sat[22:0];
        // 2*lon + 15, shifted positive by a multiple of 30
        w_lon_biased = {{3{i_longitude[LON_W-1]}}, i_longitude, 1'b0}
                       + 29'd15 + 29'(LON_BIAS);
        w_a_side.valid    = i_in_valid;
        w_a_side.status   = i_cell_missing ? ST_NO_DATA : ST_NORMAL;
        w_a_side.lat_neg  = w_lat_sat[LAT_W-1];
        w_a_side.zero_den = 1'b0;
        w_a_side.base     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
        end else if (w_en) begin
            r_a_side <= w_a_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_z    <= signed'(33'(w_lat_abs) << DIV_SHIFT);
            r_a_lonv <= w_lon_biased[27:1];
        end
    end

    // stage b: longitude shift and time base
    logic signed [24:0] w_lon_q;
    t_side              w_b_side;
    logic signed [32:0] r_b_z;
    t_side              r_b_side;

    always_comb begin
        w_lon_q       = signed'({2'd0, div15(r_a_lonv)}) - 25'(LON_OFFS);
        w_b_side      = r_a_side;
        w_b_side.base = 25'(HALF_DAY) - {{3{r_hour_offset[21]}}, r_hour_offset}
                        - (r_world_time ? w_lon_q : 25'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_side <= '0;
        end else if (w_en) begin
            r_b_side <= w_b_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_z <= r_a_z;
        end
    end

    // sin and cos of latitude magnitude
    logic signed [32:0] w_cos, w_sin;
    t_side              w_rot_side;

    ssp_rot_cordic u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_angle (r_b_z),
        .i_side  (r_b_side),
        .o_cos   (w_cos),
        .o_sin   (w_sin),
        .o_side  (w_rot_side)
    );

    // stage m: numerator and denominator of the hour-angle cosine
    logic signed [33:0] w_sin_s;
    logic [31:0]        w_cos_c;
    logic signed [49:0] w_prod;
    logic signed [50:0] r_m_num;
    logic [47:0]        r_m_den;
    t_side              r_m_side;

    always_comb begin
        w_sin_s = w_rot_side.lat_neg ? -{w_sin[32], w_sin} : {w_sin[32], w_sin};
        w_cos_c = w_cos[32] ? 32'd0 : w_cos[31:0];
        w_prod  = w_sin_s * r_decl_sine;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_side <= '0;
        end else if (w_en) begin
            r_m_side <= w_rot_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_num <= {{5{r_horizon_sine[15]}}, r_horizon_sine, 30'd0}
                       - {w_prod[49], w_prod};
            r_m_den <= {16'd0, w_cos_c} * {33'd0, r_decl_cos};
        end
    end

    // stage c: polar tests and normalization shift
    logic signed [50:0] w_den_s;
    logic [49:0]        w_num_abs;
    logic [4:0]         w_shift;
    t_side              w_c_side;
    logic [47:0]        r_c_den;
    logic [49:0]        r_c_num_abs;
    logic [4:0]         r_c_shift;
    logic               r_c_num_neg;
    t_side              r_c_side;

    always_comb begin
        w_den_s   = signed'({3'd0, r_m_den});
        w_num_abs = r_m_num[50] ? 50'(-r_m_num) : r_m_num[49:0];
        w_shift   = '0;
        for (int k = 31; k < 48; k++) begin
            if (r_m_den[k]) begin
                w_shift = 5'(k - 30);
            end
        end
        w_c_side          = r_m_side;
        w_c_side.zero_den = (r_m_den == '0);
        if (r_m_side.status == ST_NORMAL) begin
            if (r_m_num > w_den_s) begin
                w_c_side.status = ST_POLAR_NIGHT;
            end else if (r_m_num < -w_den_s) begin
                w_c_side.status = ST_MIDNIGHT_SUN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side <= '0;
        end else if (w_en) begin
            r_c_side <= w_c_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_den     <= r_m_den;
            r_c_num_abs <= w_num_abs;
            r_c_shift   <= w_shift;
            r_c_num_neg <= r_m_num[50];
        end
    end

    // stage d: shift both, clamp numerator to denominator
    logic [47:0]        w_d_full;
    logic [49:0]        w_na_full;
    logic [30:0]        w_d, w_na;
    logic [30:0]        r_d_d, r_d_na;
    logic signed [31:0] r_d_x;
    t_side              r_d_side;

    always_comb begin
        w_d_full  = r_c_den >> r_c_shift;
        w_na_full = r_c_num_abs >> r_c_shift;
        w_d       = w_d_full[30:0];
        w_na      = (w_na_full > {19'd0, w_d}) ? w_d : w_na_full[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side <= '0;
        end else if (w_en) begin
            r_d_side <= r_c_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_d  <= w_d;
            r_d_na <= w_na;
            r_d_x  <= r_c_num_neg ? -signed'({1'b0, w_na}) : signed'({1'b0, w_na});
        end
    end

    // stage e: squares
    logic [61:0]        r_e_dd, r_e_nn;
    logic signed [31:0] r_e_x;
    t_side              r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_side <= '0;
        end else if (w_en) begin
            r_e_side <= r_d_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_dd <= {31'd0, r_d_d} * {31'd0, r_d_d};
            r_e_nn <= {31'd0, r_d_na} * {31'd0, r_d_na};
            r_e_x  <= r_d_x;
        end
    end

    // stage f: difference of squares, never negative after the clamp
    logic [61:0]        r_f_diff;
    logic signed [31:0] r_f_x;
    t_side              r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_side <= '0;
        end else if (w_en) begin
            r_f_side <= r_e_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_diff <= r_e_dd - r_e_nn;
            r_f_x    <= r_e_x;
        end
    end

    // y = sqrt(den^2 - num^2)
    logic [30:0]        w_root;
    logic signed [31:0] w_sq_x;
    t_side              w_sq_side;

    ssp_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_value (r_f_diff),
        .i_x     (r_f_x),
        .i_side  (r_f_side),
        .o_root  (w_root),
        .o_x     (w_sq_x),
        .o_side  (w_sq_side)
    );

    // half arc angle
    logic signed [33:0] w_angle;
    t_side              w_vec_side;

    ssp_vec_cordic u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_x     (w_sq_x),
        .i_y     (w_root),
        .i_side  (w_sq_side),
        .o_angle (w_angle),
        .o_side  (w_vec_side)
    );

    // stage g: clamp angle, round to hours scale (divide by 2^shift first)
    logic [31:0] w_zc;
    logic [32:0] w_zr;
    logic [26:0] r_g_t;
    t_side       r_g_side;

    always_comb begin
        if (w_vec_side.zero_den) begin
            w_zc = ANG_90;  // cosine taken as zero at a pole
        end else if (w_angle[33]) begin
            w_zc = '0;
        end else if (w_angle > signed'({2'd0, ANG_180})) begin
            w_zc = ANG_180;
        end else begin
            w_zc = w_angle[31:0];
        end
        w_zr = ({1'b0, w_zc} + 33'(HALF_ROUND)) >> DIV_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_side <= '0;
        end else if (w_en) begin
            r_g_side <= w_vec_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_t <= w_zr[26:0];
        end
    end

    // stage h: divide by 15 to get the half arc in hours
    logic [22:0] w_half;
    logic [19:0] r_h_half;
    t_side       r_h_side;

    assign w_half = div15(r_g_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_side <= '0;
        end else if (w_en) begin
            r_h_side <= r_g_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_half <= w_half[19:0];
        end
    end

    // stage i: rise and set before the wrap, biased positive
    logic [24:0]       r_i_rise, r_i_set;
    logic [HOUR_W-1:0] r_i_day;
    t_side             r_i_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_side <= '0;
        end else if (w_en) begin
            r_i_side <= r_h_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_rise <= 25'(r_h_side.base) - {5'd0, r_h_half} + 25'(WRAP_BIAS);
            r_i_set  <= 25'(r_h_side.base) + {5'd0, r_h_half} + 25'(WRAP_BIAS);
            r_i_day  <= {r_h_half, 1'b0};
        end
    end

    // output register: wrap to 24 hours, apply special cases
    logic              r_out_valid;
    logic [HOUR_W-1:0] r_out_rise, r_out_set, r_out_day;
    t_status           r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_status <= r_i_side.status;
            if (r_i_side.status == ST_NORMAL) begin
                r_out_rise <= wrap24(r_i_rise);
                r_out_set  <= wrap24(r_i_set);
                r_out_day  <= r_i_day;
            end else begin
                r_out_rise <= '0;
                r_out_set  <= '0;
                r_out_day  <= (r_i_side.status == ST_MIDNIGHT_SUN)
                              ? HOUR_W'(HOUR_FULL) : '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sunrise_hour = r_out_rise;
    assign o_sunset_hour  = r_out_set;
    assign o_day_length   = r_out_day;
    assign o_cell_status  = r_out_status;

`ifndef SYNTH
    // the pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // non-normal cells carry no times
    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_cell_status != ST_NORMAL)
        |-> (o_sunrise_hour == '0) && (o_sunset_hour == '0))
        else $error("times set on a special cell");

    // wrapped times stay below 24 hours
    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_cell_status == ST_NORMAL)
        |-> (o_sunrise_hour < HOUR_W'(HOUR_FULL)) && (o_sunset_hour < HOUR_W'(HOUR_FULL)))
        else $error("wrapped time out of range");

    // day length is twice the half arc and never above 24 hours
    a_day_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_cell_status == ST_NORMAL)
        |-> !o_day_length[0] && (o_day_length <= HOUR_W'(HOUR_FULL)))
        else $error("day length malformed");

    // a held output stalls the input side
    a_stall_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output held");
`endif

endmodule
